// ===== hdl/msot_pkg.sv =====
package msot_pkg;

    localparam int SLOT_W   = 3;
    localparam int MILLIS_W = 32;
    localparam int MICROS_W = 64;

    // Broadcast from the request decoder to every slot cell.
    typedef struct packed {
        logic                alloc;
        logic                arm;
        logic                stop;
        logic [SLOT_W-1:0]   sel;
        logic [MILLIS_W-1:0] deadline;
    } cell_ctrl_t;

endpackage

// ===== hdl/msot_div.sv =====
module msot_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   amount,
    input  logic                          wrap,
    output logic                          done,
    output logic [msot_pkg::MILLIS_W-1:0] millis
);
    import msot_pkg::*;

    localparam int AMT_W   = 32;
    localparam int SUB_W   = 10;
    localparam int RECIP_W = 29;
    localparam int SHIFT   = 38;
    localparam int PROD_W  = AMT_W + RECIP_W;
    localparam int QUO_W   = PROD_W - SHIFT;
    localparam int SUM_W   = 12;

    // Rounded-up 2^38 / 1000. The product shifted right by 38 is the exact quotient of
    // every 32-bit amount by 1000.
    localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
    // 2^64 microseconds are WRAP_MS milliseconds plus 616 microseconds.
    localparam logic [MICROS_W-1:0] WRAP_MS = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;
    // The sub-millisecond sum is biased by 1000 so that it never goes negative. A counter
    // wrap takes 616 microseconds away, which leaves a bias of 384.
    localparam logic [SUM_W-1:0] BIAS      = 12'd1000;
    localparam logic [SUM_W-1:0] BIAS_WRAP = 12'd384;

    // Update phases.
    localparam logic [1:0] PH_MUL = 2'd0;
    localparam logic [1:0] PH_REM = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    logic                busy_reg, busy_next;
    logic [1:0]          phase_reg, phase_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic                wrap_reg, wrap_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [SUB_W-1:0]    rem_reg, rem_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [MILLIS_W-1:0] ms_reg, ms_next;

    logic [PROD_W-1:0]   prod;
    logic [SUB_W-1:0]    quo_x1000;
    logic [SUM_W-1:0]    sub_sum;
    logic [MILLIS_W-1:0] ms_base;

    // The millisecond count is kept as whole milliseconds plus the microseconds within
    // the current millisecond. A tick amount is split into whole milliseconds and a
    // remainder, which is folded into the running microseconds with one carry or borrow.
    always_comb
    begin
        prod      = amt_reg * RECIP;
        // The remainder is below 1024, so the low ten bits of the product carry it.
        quo_x1000 = quo_reg[SUB_W-1:0] * SUB_W'(1000);
        sub_sum   = SUM_W'(sub_reg) + SUM_W'(rem_reg) + (wrap_reg ? BIAS_WRAP : BIAS);
        ms_base   = ms_reg + MILLIS_W'(quo_reg) - (wrap_reg ? WRAP_MS[MILLIS_W-1:0] : '0);

        busy_next  = busy_reg;
        phase_next = phase_reg;
        amt_next   = amt_reg;
        wrap_next  = wrap_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        sub_next   = sub_reg;
        ms_next    = ms_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = PH_MUL;
            amt_next   = amount;
            wrap_next  = wrap;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                PH_MUL:
                begin
                    quo_next   = prod[PROD_W-1:SHIFT];
                    phase_next = PH_REM;
                end
                PH_REM:
                begin
                    rem_next   = amt_reg[SUB_W-1:0] - quo_x1000;
                    phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    busy_next  = 1'b0;
                    phase_next = PH_MUL;
                    if (sub_sum >= 12'd2000)
                    begin
                        sub_next = SUB_W'(sub_sum - 12'd2000);
                        ms_next  = ms_base + MILLIS_W'(1);
                    end
                    else if (sub_sum >= 12'd1000)
                    begin
                        sub_next = SUB_W'(sub_sum - 12'd1000);
                        ms_next  = ms_base;
                    end
                    else
                    begin
                        sub_next = sub_sum[SUB_W-1:0];
                        ms_next  = ms_base - MILLIS_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_MUL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_MUL;
            sub_reg   <= '0;
            ms_reg    <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            ms_reg    <= ms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg  <= amt_next;
        wrap_reg <= wrap_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done   = busy_reg && (phase_reg == PH_SUM);
    assign millis = ms_reg;

endmodule

// ===== hdl/msot_cell.sv =====
module msot_cell
#(
    parameter int CELL_IDX = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  msot_pkg::cell_ctrl_t          ctrl,
    input  logic [msot_pkg::MILLIS_W-1:0] millis,
    input  logic                          shift,
    input  logic                          take,
    input  logic                          token_in,
    input  logic                          alloc_in,
    output logic                          token_out,
    output logic                          alloc_out,
    output logic                          hit
);
    import msot_pkg::*;

    localparam bit ADDRESSABLE = CELL_IDX < (1 << SLOT_W);

    logic                token_reg, token_next;
    logic                alloc_reg, alloc_next;
    logic                armed_reg, armed_next;
    logic [MILLIS_W-1:0] deadline_reg, deadline_next;
    logic                selected;

    assign selected = ADDRESSABLE && (ctrl.sel == SLOT_W'(CELL_IDX));
    assign hit      = token_reg && alloc_reg && armed_reg && (deadline_reg <= millis);

    always_comb
    begin
        token_next    = shift ? token_in : token_reg;
        // Slots are handed out in order: the first cell not yet taken claims it.
        alloc_next    = alloc_reg || (ctrl.alloc && alloc_in);
        armed_next    = armed_reg;
        deadline_next = deadline_reg;
        if (take && hit)
        begin
            armed_next = 1'b0;
        end
        else if (ctrl.arm && selected)
        begin
            armed_next    = 1'b1;
            deadline_next = ctrl.deadline;
        end
        else if (ctrl.stop && selected)
        begin
            armed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
            alloc_reg <= 1'b0;
            armed_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
            alloc_reg <= alloc_next;
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
    end

    assign token_out = token_reg;
    assign alloc_out = alloc_reg;

endmodule

// ===== hdl/multi_slot_oneshot_timer_top.sv =====
// Microsecond counter with SLOT_COUNT one-shot timer slots. Each request transfer yields
// zero or more expiry events (kind 1) followed by exactly one reply (kind 0, last 1).
// Allocate, arm, stop and read requests are accepted and applied, then the reply is
// presented. A tick is accepted and added to the counter, then the millisecond unit
// runs its multiply, remainder and sum phases (a reciprocal multiply splits the tick
// amount into whole milliseconds and a remainder, which is then folded into a running
// count of microseconds within the current millisecond), then a scan token walks down
// the row of slot cells, and last the reply is presented. A stalled output holds the
// scan and the reply. The expiry compare is a plain unsigned comparison of the
// deadline against the millisecond count, with no wrap handling.
module multi_slot_oneshot_timer_top
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    req_type,
    input  logic [31:0]                   tick_amount,
    input  logic [msot_pkg::SLOT_W-1:0]   slot_index,
    input  logic [msot_pkg::MILLIS_W-1:0] millis_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [msot_pkg::SLOT_W-1:0]   slot,
    output logic                          status,
    output logic [msot_pkg::MICROS_W-1:0] micros_now,
    output logic [msot_pkg::MILLIS_W-1:0] millis_now,
    output logic                          last
);
    import msot_pkg::*;

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // Request codes.
    localparam logic [2:0] REQ_TICK_ONE = 3'd0;
    localparam logic [2:0] REQ_TICK_AMT = 3'd1;
    localparam logic [2:0] REQ_ALLOC    = 3'd2;
    localparam logic [2:0] REQ_ARM_ABS  = 3'd3;
    localparam logic [2:0] REQ_ARM_REL  = 3'd4;
    localparam logic [2:0] REQ_STOP     = 3'd5;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_REPLY = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [MICROS_W-1:0] micro_reg, micro_next;
    logic [CNT_W-1:0]    alloc_cnt_reg, alloc_cnt_next;
    logic [SLOT_W-1:0]   rep_slot_reg, rep_slot_next;
    logic                rep_status_reg, rep_status_next;

    logic                out_valid_reg, out_valid_next;
    logic                kind_reg, kind_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                status_reg, status_next;
    logic [MICROS_W-1:0] micros_reg, micros_next;
    logic [MILLIS_W-1:0] millis_reg, millis_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                is_tick;
    logic                adv;
    logic                scanning;
    logic [31:0]         tick_amt;
    logic                micro_carry;
    logic [MICROS_W-1:0] micro_sum;
    logic                div_done;
    logic [MILLIS_W-1:0] millis_cur;
    cell_ctrl_t          ctrl;

    logic [SLOT_COUNT-1:0] token_vec;
    logic [SLOT_COUNT-1:0] alloc_vec;
    logic [SLOT_COUNT-1:0] hit_vec;
    logic                  any_hit;
    logic [SLOT_W-1:0]     ev_slot;

    // Requests are taken only between requests; the output register still lets the
    // previous reply wait for the consumer while the next request is accepted.
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_tick  = (req_type == REQ_TICK_ONE) || (req_type == REQ_TICK_AMT);

    // The output register can take a new result when it is empty or being drained.
    assign adv      = !out_valid_reg || out_ready;
    assign scanning = (state_reg == ST_SCAN);

    // The carry out of the counter tells the millisecond unit that the counter wrapped.
    assign tick_amt = (req_type == REQ_TICK_ONE) ? 32'd1 : tick_amount;
    assign {micro_carry, micro_sum} = {1'b0, micro_reg} + {33'd0, tick_amt};

    // The millisecond count is brought up to date after every tick and held until the
    // next one, so it always matches the counter outside of a tick.
    msot_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept && is_tick),
        .amount (tick_amt),
        .wrap   (micro_carry),
        .done   (div_done),
        .millis (millis_cur)
    );

    // Broadcast of allocate, arm and stop to the slot cells.
    always_comb
    begin
        ctrl.alloc    = accept && (req_type == REQ_ALLOC) &&
                        (alloc_cnt_reg != CNT_W'(SLOT_COUNT));
        ctrl.arm      = accept && ((req_type == REQ_ARM_ABS) || (req_type == REQ_ARM_REL));
        ctrl.stop     = accept && (req_type == REQ_STOP);
        ctrl.sel      = slot_index;
        ctrl.deadline = (req_type == REQ_ARM_REL) ? (millis_cur + millis_value)
                                                  : millis_value;
    end

    // Row of slot cells. The scan token enters cell 0 when the millisecond unit finishes
    // and moves one cell per cycle whenever the output register can take a result, so
    // expiry events leave in slot order and a stalled consumer simply holds the scan.
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        logic token_in;
        logic alloc_in;
        if (i == 0)
        begin : g_head
            assign token_in = div_done;
            assign alloc_in = 1'b1;
        end
        else
        begin : g_link
            assign token_in = token_vec[i-1];
            assign alloc_in = alloc_vec[i-1];
        end
        msot_cell #(.CELL_IDX(i)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .millis    (millis_cur),
            .shift     (div_done || (scanning && adv)),
            .take      (scanning && adv),
            .token_in  (token_in),
            .alloc_in  (alloc_in),
            .token_out (token_vec[i]),
            .alloc_out (alloc_vec[i]),
            .hit       (hit_vec[i])
        );
    end

    // Only the cell holding the token can report a hit, so an OR of indexes suffices.
    always_comb
    begin
        ev_slot = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_vec[i])
            begin
                ev_slot = ev_slot | SLOT_W'(i);
            end
        end
    end
    assign any_hit = |hit_vec;

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        micro_next      = micro_reg;
        alloc_cnt_next  = alloc_cnt_reg;
        rep_slot_next   = rep_slot_reg;
        rep_status_next = rep_status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rep_slot_next   = '0;
                    rep_status_next = 1'b0;
                    if (is_tick)
                    begin
                        micro_next = micro_sum;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        if (req_type == REQ_ALLOC)
                        begin
                            if (alloc_cnt_reg == CNT_W'(SLOT_COUNT))
                            begin
                                rep_status_next = 1'b1;
                            end
                            else
                            begin
                                rep_slot_next  = SLOT_W'(alloc_cnt_reg);
                                alloc_cnt_next = alloc_cnt_reg + CNT_W'(1);
                            end
                        end
                        state_next = ST_REPLY;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (adv && token_vec[SLOT_COUNT-1])
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: expiry events during the scan, then the reply.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        micros_next    = micros_reg;
        millis_next    = millis_reg;
        last_next      = last_reg;
        if (scanning && adv && any_hit)
        begin
            out_valid_next = 1'b1;
            kind_next      = 1'b1;
            slot_next      = ev_slot;
            status_next    = 1'b0;
            micros_next    = micro_reg;
            millis_next    = millis_cur;
            last_next      = 1'b0;
        end
        else if ((state_reg == ST_REPLY) && adv)
        begin
            out_valid_next = 1'b1;
            kind_next      = 1'b0;
            slot_next      = rep_slot_reg;
            status_next    = rep_status_reg;
            micros_next    = micro_reg;
            millis_next    = millis_cur;
            last_next      = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            micro_reg     <= '0;
            alloc_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            micro_reg     <= micro_next;
            alloc_cnt_reg <= alloc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_slot_reg   <= rep_slot_next;
        rep_status_reg <= rep_status_next;
        kind_reg       <= kind_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        micros_reg     <= micros_next;
        millis_reg     <= millis_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign slot       = slot_reg;
    assign status     = status_reg;
    assign micros_now = micros_reg;
    assign millis_now = millis_reg;
    assign last       = last_reg;

endmodule
